@@ hw/rtl/assert_macros.svh @@
// assert_macros.svh: concurrent assertion macros shared by the RTL.
// No dependencies; compiled out when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// antecedent holds -> consequent holds in the same cycle
`define ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
// antecedent holds -> consequent holds in the next cycle
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_SAME(label, clk, rstn, ante, cons)
`define ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif

`endif

@@ hw/rtl/crccs_pkg.sv @@
// crccs_pkg: constants, types and the zero-byte operator ROMs for the CRC-32
// combine/subtract block. No dependencies.
package crccs_pkg;

    localparam int CRC_BITS    = 32;
    localparam int LENGTH_BITS = 32;
    localparam int IDX_W       = $clog2(CRC_BITS);

    localparam logic [CRC_BITS-1:0] POLY_FWD = 32'hEDB88320;
    localparam logic [CRC_BITS-1:0] POLY_INV = 32'hDB710641;
    // matrix for length bit 0 is the 8-bit (one byte) operator
    localparam logic [IDX_W-1:0]    FIRST_POWER = IDX_W'(3);

    localparam logic CMD_COMBINE  = 1'b0;
    localparam logic CMD_SUBTRACT = 1'b1;

    // matrix: one CRC_BITS word per column (column i = image of bit i)
    typedef logic [CRC_BITS-1:0][CRC_BITS-1:0] mat_t;
    typedef mat_t [CRC_BITS-1:0]               rom_t;

    // request to the matrix-vector unit
    typedef struct packed {
        logic                inv;
        logic [IDX_W-1:0]    idx;
        logic [CRC_BITS-1:0] vec;
    } mv_req_t;

    // finished item from the sequencer
    typedef struct packed {
        logic                valid;
        logic [CRC_BITS-1:0] crc;
    } done_t;

    function automatic logic [CRC_BITS-1:0] mat_vec(mat_t m, logic [CRC_BITS-1:0] v);
        logic [CRC_BITS-1:0] acc;
        acc = '0;
        for (int i = 0; i < CRC_BITS; i++) begin
            if (v[i]) acc = acc ^ m[i];
        end
        return acc;
    endfunction

    // elaboration-time ROM build: base one-bit operator, then repeated squaring
    function automatic rom_t build_rom(logic inv);
        rom_t r;
        r = '0;
        if (inv) begin
            r[0][CRC_BITS-1] = POLY_INV;
            for (int i = 1; i < CRC_BITS; i++)
                r[0][i-1] = CRC_BITS'(1) << i;
        end else begin
            r[0][0] = POLY_FWD;
            for (int i = 1; i < CRC_BITS; i++)
                r[0][i] = CRC_BITS'(1) << (i - 1);
        end
        for (int k = 1; k < CRC_BITS; k++) begin
            for (int i = 0; i < CRC_BITS; i++)
                r[k][i] = mat_vec(r[k-1], r[k-1][i]);
        end
        return r;
    endfunction

    localparam rom_t FWD_ROM = build_rom(1'b0);
    localparam rom_t INV_ROM = build_rom(1'b1);

endpackage

@@ hw/rtl/crccs_matvec.sv @@
// crccs_matvec: shared GF(2) 32x32 matrix-vector product unit, matrix picked
// from the constant operator ROMs. Depends on crccs_pkg.
module crccs_matvec (
    input  crccs_pkg::mv_req_t              req,
    output logic [crccs_pkg::CRC_BITS-1:0]  product
);
    import crccs_pkg::*;

    mat_t                m_sel;
    logic [CRC_BITS-1:0] row;

    always_comb begin
        m_sel = req.inv ? INV_ROM[req.idx] : FWD_ROM[req.idx];
        row   = '0;
        for (int r = 0; r < CRC_BITS; r++) begin
            for (int i = 0; i < CRC_BITS; i++)
                row[i] = m_sel[i][r];
            product[r] = ^(row & req.vec);
        end
    end

endmodule

@@ hw/rtl/crccs_ctrl.sv @@
// crccs_ctrl: sequencer that walks the length bits, one matrix product per
// bit through crccs_matvec. Depends on crccs_pkg and assert_macros.svh.
`include "assert_macros.svh"
module crccs_ctrl (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_command,
    input  logic [crccs_pkg::CRC_BITS-1:0]    s_crc_first,
    input  logic [crccs_pkg::CRC_BITS-1:0]    s_crc_second,
    input  logic [31:0]                       s_length_bytes,
    input  logic                              out_free,
    output crccs_pkg::mv_req_t                mv_req,
    input  logic [crccs_pkg::CRC_BITS-1:0]    mv_product,
    output crccs_pkg::done_t                  done
);
    import crccs_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } state_t;

    state_t                 state_reg, state_next;
    logic [LENGTH_BITS-1:0] len_reg, len_next;
    logic [IDX_W-1:0]       idx_reg, idx_next;
    logic [CRC_BITS-1:0]    vec_reg, vec_next;
    logic [CRC_BITS-1:0]    first_reg, first_next;
    logic [CRC_BITS-1:0]    second_reg, second_next;
    logic                   cmd_reg, cmd_next;
    logic                   zero_len_reg, zero_len_next;
    logic [LENGTH_BITS-1:0] len_in;
    logic                   accept;

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;
    assign len_in  = LENGTH_BITS'(s_length_bytes);

    assign mv_req.inv = cmd_reg;
    assign mv_req.idx = idx_reg;
    assign mv_req.vec = vec_reg;

    always_comb begin
        state_next    = state_reg;
        len_next      = len_reg;
        idx_next      = idx_reg;
        vec_next      = vec_reg;
        first_next    = first_reg;
        second_next   = second_reg;
        cmd_next      = cmd_reg;
        zero_len_next = zero_len_reg;
        done.valid    = 1'b0;
        if (zero_len_reg)
            done.crc = first_reg;
        else if (cmd_reg == CMD_COMBINE)
            done.crc = vec_reg ^ second_reg;
        else
            done.crc = vec_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    len_next      = len_in;
                    idx_next      = FIRST_POWER;
                    cmd_next      = s_command;
                    first_next    = s_crc_first;
                    second_next   = s_crc_second;
                    zero_len_next = (len_in == '0);
                    // subtract runs the inverse operator on the XOR of both
                    vec_next      = (s_command == CMD_SUBTRACT) ?
                                    (s_crc_first ^ s_crc_second) : s_crc_first;
                    state_next    = ST_RUN;
                end
            end
            ST_RUN: begin
                if (len_reg != '0) begin
                    if (len_reg[0]) vec_next = mv_product;
                    len_next = len_reg >> 1;
                    idx_next = idx_reg + IDX_W'(1);   // wraps mod CRC_BITS
                end else if (out_free) begin
                    done.valid = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
        len_reg      <= len_next;
        idx_reg      <= idx_next;
        vec_reg      <= vec_next;
        first_reg    <= first_next;
        second_reg   <= second_next;
        cmd_reg      <= cmd_next;
        zero_len_reg <= zero_len_next;
    end

    `ASSERT_NEXT(a_accept_busy, aclk, aresetn, accept, (state_reg == ST_RUN) && !s_ready)
    `ASSERT_SAME(a_done_only_at_end, aclk, aresetn, done.valid, (len_reg == '0) && out_free)
    `ASSERT_NEXT(a_len_shrinks, aclk, aresetn, (state_reg == ST_RUN) && (len_reg != '0), (state_reg == ST_RUN) && (len_reg < $past(len_reg)))

endmodule

@@ hw/rtl/crc32_combine_subtract.sv @@
// crc32_combine_subtract: top level, CRC-32 combine/subtract with output register.
// Depends on crccs_pkg, crccs_matvec, crccs_ctrl.
//
//  channel | handshake         | payload
//  --------+-------------------+-----------------------------------------------
//  input   | s_valid / s_ready | s_command, s_crc_first, s_crc_second, s_length_bytes
//  result  | m_valid / m_ready | m_crc_result
//
// An item makes one pass of the shared matrix-vector unit per length bit, up to and
// including the highest set bit (0..32 passes), then moves on to the result register.
// s_ready is high only while no item is in progress; the result register lets the
// next item be accepted while a result waits. A stalled result holds the
// sequencer at its last step. Reset (aresetn, synchronous) clears control only.
module crc32_combine_subtract (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_command,
    input  logic [crccs_pkg::CRC_BITS-1:0]  s_crc_first,
    input  logic [crccs_pkg::CRC_BITS-1:0]  s_crc_second,
    input  logic [31:0]                     s_length_bytes,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [crccs_pkg::CRC_BITS-1:0]  m_crc_result
);
    import crccs_pkg::*;

    mv_req_t             mv_req;
    logic [CRC_BITS-1:0] mv_product;
    done_t               done;
    logic                out_free;
    logic                m_valid_reg, m_valid_next;
    logic [CRC_BITS-1:0] m_crc_reg, m_crc_next;

    crccs_matvec u_matvec (
        .req     (mv_req),
        .product (mv_product)
    );

    crccs_ctrl u_ctrl (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_command      (s_command),
        .s_crc_first    (s_crc_first),
        .s_crc_second   (s_crc_second),
        .s_length_bytes (s_length_bytes),
        .out_free       (out_free),
        .mv_req         (mv_req),
        .mv_product     (mv_product),
        .done           (done)
    );

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        m_crc_next   = m_crc_reg;
        if (done.valid) begin
            m_valid_next = 1'b1;
            m_crc_next   = done.crc;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
        m_crc_reg <= m_crc_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_crc_result = m_crc_reg;

endmodule

@@ test/crc32_combine_subtract_test.sv @@
// Self-checking bench for crc32_combine_subtract: a directed table, then random
// CRC-32 combine/subtract requests under several idle and stall patterns.
// Depends on crccs_pkg and the crc32_combine_subtract RTL.
module crc32_combine_subtract_test;
    import crccs_pkg::*;

    localparam int CYCLE_LIMIT     = 1_000_000;
    localparam int ITEMS_PER_PHASE = 246;
    localparam int SETTLE_CYCLES   = 40;     // outlasts the longest item
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int N_PHASES        = 4;
    localparam int N_DIRECTED      = 17;

    typedef struct packed {
        logic                cmd;
        logic [CRC_BITS-1:0] first;
        logic [CRC_BITS-1:0] second;
        logic [31:0]         len;
        logic                known;   // result typed in below, not predicted
        logic [CRC_BITS-1:0] result;
    } crc_request_t;

    // zero length passes crc_first through; combine on a zero first CRC gives
    // crc_second; a zero vector stays zero under either operator
    crc_request_t directed_requests [N_DIRECTED] = '{
        '{CMD_COMBINE,  32'h12345678, 32'h9ABCDEF0, 32'h00000000, 1'b1, 32'h12345678},
        '{CMD_SUBTRACT, 32'hFFFFFFFF, 32'h00000000, 32'h00000000, 1'b1, 32'hFFFFFFFF},
        '{CMD_SUBTRACT, 32'h00000000, 32'hFFFFFFFF, 32'h00000000, 1'b1, 32'h00000000},
        '{CMD_COMBINE,  32'h00000000, 32'hDEADBEEF, 32'hFFFFFFFF, 1'b1, 32'hDEADBEEF},
        '{CMD_COMBINE,  32'h00000000, 32'hFFFFFFFF, 32'h00000001, 1'b1, 32'hFFFFFFFF},
        '{CMD_SUBTRACT, 32'h00000000, 32'h00000000, 32'hFFFFFFFF, 1'b1, 32'h00000000},
        '{CMD_SUBTRACT, 32'hA5A5A5A5, 32'hA5A5A5A5, 32'h80000000, 1'b1, 32'h00000000},
        '{CMD_COMBINE,  32'hFFFFFFFF, 32'hFFFFFFFF, 32'h00000001, 1'b0, 32'h0},
        '{CMD_SUBTRACT, 32'hFFFFFFFF, 32'h00000000, 32'h00000001, 1'b0, 32'h0},
        '{CMD_COMBINE,  32'h00000001, 32'h00000000, 32'h80000000, 1'b0, 32'h0},
        '{CMD_COMBINE,  32'h80000000, 32'h00000000, 32'h20000000, 1'b0, 32'h0},
        '{CMD_SUBTRACT, 32'h80000000, 32'h00000001, 32'h40000000, 1'b0, 32'h0},
        '{CMD_COMBINE,  32'hCBF43926, 32'h12345678, 32'hFFFFFFFF, 1'b0, 32'h0},
        '{CMD_SUBTRACT, 32'hCBF43926, 32'h12345678, 32'hFFFFFFFF, 1'b0, 32'h0},
        '{CMD_COMBINE,  32'h12345678, 32'h9ABCDEF0, 32'h0000000A, 1'b0, 32'h0},
        '{CMD_SUBTRACT, 32'h12345678, 32'h9ABCDEF0, 32'h0000000A, 1'b0, 32'h0},
        '{CMD_COMBINE,  32'hFFFFFFFF, 32'h00000000, 32'h0000FFFF, 1'b0, 32'h0}
    };

    logic                aclk           = 1'b0;
    logic                aresetn        = 1'b0;
    logic                s_valid        = 1'b0;
    logic                s_ready;
    logic                s_command      = 1'b0;
    logic [CRC_BITS-1:0] s_crc_first    = '0;
    logic [CRC_BITS-1:0] s_crc_second   = '0;
    logic [31:0]         s_length_bytes = '0;
    logic                m_valid;
    logic                m_ready        = 1'b0;
    logic [CRC_BITS-1:0] m_crc_result;

    // zero-byte operators: [power][column], column c = image of bit c
    logic [CRC_BITS-1:0] fwd_zero_op [CRC_BITS][CRC_BITS];
    logic [CRC_BITS-1:0] inv_zero_op [CRC_BITS][CRC_BITS];

    logic [CRC_BITS-1:0] crc_results_due [$];
    int                  mismatches     = 0;
    int unsigned         cycle_count    = 0;
    int                  send_idle_pct  = 0;
    int                  recv_stall_pct = 0;
    int                  hold_off_left  = 0;

    crc32_combine_subtract DUT (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_command      (s_command),
        .s_crc_first    (s_crc_first),
        .s_crc_second   (s_crc_second),
        .s_length_bytes (s_length_bytes),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_crc_result   (m_crc_result)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    function automatic logic [CRC_BITS-1:0] apply_zero_op(input logic inv, input int k,
                                                          input logic [CRC_BITS-1:0] v);
        logic [CRC_BITS-1:0] acc;
        acc = '0;
        for (int j = 0; j < CRC_BITS; j++) begin
            if (v[j]) acc = acc ^ (inv ? inv_zero_op[k][j] : fwd_zero_op[k][j]);
        end
        return acc;
    endfunction

    function automatic logic [CRC_BITS-1:0] predict_crc_result(input crc_request_t r);
        logic [CRC_BITS-1:0] v;
        if (r.len == '0) return r.first;
        if (r.cmd == CMD_COMBINE && r.first == '0) return r.second;
        v = (r.cmd == CMD_COMBINE) ? r.first : (r.first ^ r.second);
        // length bit i uses the 2^(i+3)-bit operator, power index wrapping mod 32
        for (int i = 0; i < LENGTH_BITS; i++) begin
            if (r.len[i])
                v = apply_zero_op(r.cmd == CMD_SUBTRACT, (int'(FIRST_POWER) + i) % CRC_BITS, v);
        end
        return (r.cmd == CMD_COMBINE) ? (v ^ r.second) : v;
    endfunction

    function automatic crc_request_t random_request();
        crc_request_t r;
        r        = '0;
        r.cmd    = 1'($urandom_range(1));
        case ($urandom_range(15))
            0:       r.first = '0;
            1:       r.first = '1;
            default: r.first = $urandom;
        endcase
        case ($urandom_range(15))
            0:       r.second = r.first;   // subtract of equal CRCs
            1:       r.second = '0;
            2:       r.second = '1;
            default: r.second = $urandom;
        endcase
        case ($urandom_range(9))
            0:       r.len = '0;
            1:       r.len = $urandom_range(255, 1);
            2:       r.len = 32'h1 << $urandom_range(31);
            3:       r.len = '1;
            default: r.len = $urandom >> $urandom_range(31);
        endcase
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [CRC_BITS-1:0] got,
                                   input logic [CRC_BITS-1:0] want);
        mismatches++;
        $display("MISMATCH cycle %0d: %s got %08h expected %08h",
                 cycle_count, what, got, want);
    endtask

    task automatic send_request(input crc_request_t r);
        while ($urandom_range(99) < send_idle_pct) begin
            @(negedge aclk);
            s_valid <= 1'b0;
        end
        @(negedge aclk);
        s_valid        <= 1'b1;
        s_command      <= r.cmd;
        s_crc_first    <= r.first;
        s_crc_second   <= r.second;
        s_length_bytes <= r.len;
        do @(posedge aclk); while (s_ready !== 1'b1);
        crc_results_due.push_back(r.known ? r.result : predict_crc_result(r));
    endtask

    // sender stops offering until every result is back
    task automatic wait_results_drained();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (crc_results_due.size() != 0) @(posedge aclk);
    endtask

    // receiver: random stalls plus one long hold-off in phase 0
    always @(negedge aclk) begin
        if (hold_off_left > 0) begin
            m_ready       <= 1'b0;
            hold_off_left = hold_off_left - 1;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (crc_results_due.size() == 0) begin
                report_mismatch("crc_result with nothing pending", m_crc_result, '0);
            end else begin
                if (m_crc_result !== crc_results_due[0])
                    report_mismatch("crc_result", m_crc_result, crc_results_due[0]);
                void'(crc_results_due.pop_front());
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        for (int c = 0; c < CRC_BITS; c++) begin
            fwd_zero_op[0][c] = (c == 0) ? POLY_FWD : (CRC_BITS'(1) << (c - 1));
            inv_zero_op[0][c] = (c == CRC_BITS - 1) ? POLY_INV : (CRC_BITS'(1) << (c + 1));
        end
        // each power is the square of the one below
        for (int k = 1; k < CRC_BITS; k++) begin
            for (int c = 0; c < CRC_BITS; c++) begin
                fwd_zero_op[k][c] = apply_zero_op(1'b0, k - 1, fwd_zero_op[k-1][c]);
                inv_zero_op[k][c] = apply_zero_op(1'b1, k - 1, inv_zero_op[k-1][c]);
            end
        end

        repeat (2) @(negedge aclk);
        aresetn <= 1'b1;

        foreach (directed_requests[i]) send_request(directed_requests[i]);
        wait_results_drained();

        for (int phase = 0; phase < N_PHASES; phase++) begin
            case (phase)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 85; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 85; end
                default: begin send_idle_pct = 12; recv_stall_pct = 12; end
            endcase
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                // long receiver hold-off while items keep coming: input must back up
                if (phase == 0 && n == 40) hold_off_left = HOLD_OFF_CYCLES;
                send_request(random_request());
            end
            wait_results_drained();
        end

        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

@@ crc32_combine_subtract.f @@
+incdir+hw/rtl
hw/rtl/crccs_pkg.sv
hw/rtl/crccs_matvec.sv
hw/rtl/crccs_ctrl.sv
hw/rtl/crc32_combine_subtract.sv
test/crc32_combine_subtract_test.sv
